FILE: hw/rtl/fsc_pkg.sv
// shared types and constants for the sum16 frame receiver
`timescale 1ns / 1ps
`default_nettype none

package fsc_pkg;

   localparam logic [7:0]  START_BYTE     = 8'hFA;
   localparam logic [7:0]  END_BYTE       = 8'hFC;
   localparam logic [7:0]  DEFAULT_HEADER = 8'h5A;
   localparam int unsigned FRAME_OVERHEAD = 8;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
   localparam logic [1:0] STATUS_ABORT   = 2'd2;

   typedef struct packed {
      logic       kind;
      logic [7:0] index;
      logic [7:0] value;
      logic [1:0] status;
      logic [7:0] command;
      logic [7:0] length;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/fsc_in_stage.sv
// input register for received words
`timescale 1ns / 1ps
`default_nettype none

module fsc_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       advance,
   output logic            byte_valid,
   output logic [7:0]      byte_data
);

   logic       vld_ff, vld_in;
   logic [7:0] byte_ff;

   assign req_ready = !vld_ff || advance;
   assign vld_in    = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_valid = vld_ff;
   assign byte_data  = byte_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/fsc_deframer.sv
// frame phase tracking, running checksum and result formation
`timescale 1ns / 1ps
`default_nettype none

module fsc_deframer #(
   parameter int unsigned MAX_FRAME_BYTES = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   input  wire logic [7:0] expected_header,
   output logic            has_result,
   output fsc_pkg::result_type result
);

   localparam int unsigned LenW = $clog2(MAX_FRAME_BYTES);
   localparam logic [15:0] LenLimit = 16'(MAX_FRAME_BYTES - fsc_pkg::FRAME_OVERHEAD);

   typedef enum logic [3:0] {
      PH_HEAD1, PH_HEAD2, PH_LEN1, PH_LEN2, PH_CMD, PH_DATA, PH_CS1, PH_CS2, PH_END
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [LenW-1:0]  len_ff, len_in;
   logic [LenW-1:0]  count_ff, count_in;
   logic [7:0]       len_low_ff, len_low_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       sum_low_ff, sum_low_in;
   logic             sum_ok_ff, sum_ok_in;

   logic [15:0]      full_len;
   logic [LenW-1:0]  count_next;
   logic [LenW+7:0]  len_ext, count_ext;

   assign full_len   = {rx_byte, len_low_ff};
   assign count_next = count_ff + LenW'(1);
   assign len_ext    = {8'd0, len_ff};
   assign count_ext  = {8'd0, count_ff};

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      count_in   = count_ff;
      len_low_in = len_low_ff;
      cmd_in     = cmd_ff;
      sum_in     = sum_ff;
      sum_low_in = sum_low_ff;
      sum_ok_in  = sum_ok_ff;
      has_result = 1'b0;
      result     = '0;
      case (phase_ff)
         PH_HEAD1: begin
            if (rx_byte == fsc_pkg::START_BYTE) begin
               phase_in = PH_HEAD2;
            end
         end
         PH_HEAD2: begin
            if (rx_byte == expected_header) begin
               sum_in   = 16'(fsc_pkg::START_BYTE) + 16'(rx_byte);
               phase_in = PH_LEN1;
            end else if (rx_byte != fsc_pkg::START_BYTE) begin
               phase_in = PH_HEAD1;
            end
         end
         PH_LEN1: begin
            len_low_in = rx_byte;
            sum_in     = sum_ff + 16'(rx_byte);
            phase_in   = PH_LEN2;
         end
         PH_LEN2: begin
            sum_in = sum_ff + 16'(rx_byte);
            if (full_len > LenLimit) begin
               // oversize length: report the abort and hunt again
               len_in        = '0;
               phase_in      = PH_HEAD1;
               has_result    = 1'b1;
               result.kind   = fsc_pkg::KIND_REPORT;
               result.status = fsc_pkg::STATUS_ABORT;
            end else begin
               len_in   = full_len[LenW-1:0];
               phase_in = PH_CMD;
            end
         end
         PH_CMD: begin
            cmd_in   = rx_byte;
            sum_in   = sum_ff + 16'(rx_byte);
            count_in = '0;
            phase_in = (len_ff != '0) ? PH_DATA : PH_CS1;
         end
         PH_DATA: begin
            sum_in   = sum_ff + 16'(rx_byte);
            count_in = count_next;
            if (count_next >= len_ff) begin
               phase_in = PH_CS1;
            end
            has_result     = 1'b1;
            result.kind    = fsc_pkg::KIND_PAYLOAD;
            result.index   = count_ext[7:0];
            result.value   = rx_byte;
            result.status  = fsc_pkg::STATUS_OK;
            result.command = cmd_ff;
            result.length  = len_ext[7:0];
         end
         PH_CS1: begin
            sum_low_in = rx_byte;
            phase_in   = PH_CS2;
         end
         PH_CS2: begin
            // running sum no longer moves, so settle the match here
            sum_ok_in = ({rx_byte, sum_low_ff} == sum_ff);
            phase_in  = PH_END;
         end
         PH_END: begin
            if (rx_byte == fsc_pkg::END_BYTE) begin
               phase_in       = PH_HEAD1;
               has_result     = 1'b1;
               result.kind    = fsc_pkg::KIND_REPORT;
               result.status  = sum_ok_ff ? fsc_pkg::STATUS_OK : fsc_pkg::STATUS_BAD_SUM;
               result.command = cmd_ff;
               result.length  = len_ext[7:0];
            end else if (rx_byte == fsc_pkg::START_BYTE) begin
               phase_in = PH_HEAD2;
            end else begin
               phase_in = PH_HEAD1;
            end
         end
         default: begin
            phase_in = PH_HEAD1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEAD1;
         len_ff     <= '0;
         count_ff   <= '0;
         len_low_ff <= '0;
         cmd_ff     <= '0;
         sum_ff     <= '0;
         sum_low_ff <= '0;
         sum_ok_ff  <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         len_ff     <= len_in;
         count_ff   <= count_in;
         len_low_ff <= len_low_in;
         cmd_ff     <= cmd_in;
         sum_ff     <= sum_in;
         sum_low_ff <= sum_low_in;
         sum_ok_ff  <= sum_ok_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/fsc_out_stage.sv
// result register towards the response channel
`timescale 1ns / 1ps
`default_nettype none

module fsc_out_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire fsc_pkg::result_type result,
   output logic            slot_free,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_result_kind,
   output logic [7:0]      rsp_payload_index,
   output logic [7:0]      rsp_payload_value,
   output logic [1:0]      rsp_frame_status,
   output logic [7:0]      rsp_frame_command,
   output logic [7:0]      rsp_frame_length
);

   logic                vld_ff, vld_in;
   fsc_pkg::result_type res_ff;

   assign slot_free = !vld_ff || rsp_ready;
   assign vld_in    = load ? 1'b1 : (rsp_ready ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_valid         = vld_ff;
   assign rsp_result_kind   = res_ff.kind;
   assign rsp_payload_index = res_ff.index;
   assign rsp_payload_value = res_ff.value;
   assign rsp_frame_status  = res_ff.status;
   assign rsp_frame_command = res_ff.command;
   assign rsp_frame_length  = res_ff.length;

endmodule

`default_nettype wire

FILE: hw/rtl/frame_receiver_sum16_check_unit.sv
// top level of the byte stream frame receiver with 16-bit additive checksum
// path: an accepted word is held in the input register, and its result is loaded into the output register onto rsp
// throughput: one word per cycle unless a waiting result stalls it; the phase and sum update sets this figure
// a waiting result stalls the input only when the word behind it also yields a result
// reset: synchronous, active high; hunt restarts and the header register returns to 0x5a
`timescale 1ns / 1ps
`default_nettype none

module frame_receiver_sum16_check_unit #(
   parameter int unsigned MAX_FRAME_BYTES = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_result_kind,
   output logic [7:0]      rsp_payload_index,
   output logic [7:0]      rsp_payload_value,
   output logic [1:0]      rsp_frame_status,
   output logic [7:0]      rsp_frame_command,
   output logic [7:0]      rsp_frame_length,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_expected_header_byte
);

   logic                byte_valid;
   logic [7:0]          byte_data;
   logic                advance;
   logic                has_result;
   logic                slot_free;
   logic [7:0]          header_ff;
   fsc_pkg::result_type result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= fsc_pkg::DEFAULT_HEADER;
      end else if (csr_valid && csr_ready) begin
         header_ff <= csr_expected_header_byte;
      end
   end

   // a word with no result never waits on the output side
   assign advance = byte_valid && (!has_result || slot_free);

   fsc_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   fsc_deframer #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_deframer (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .rx_byte         (byte_data),
      .expected_header (header_ff),
      .has_result      (has_result),
      .result          (result)
   );

   fsc_out_stage u_out (
      .clock             (clock),
      .reset             (reset),
      .load              (advance && has_result),
      .result            (result),
      .slot_free         (slot_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_value (rsp_payload_value),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length)
   );

endmodule

`default_nettype wire
